/* rtl/tna_pkg.sv */
// Package for the triangle normal and area block.
// Controller states, datapath operations and the command/status structs.
// No dependencies.
package tna_pkg;

  localparam int CROSS_TERMS = 6;
  localparam int SQ_TERMS    = 9;
  localparam int SQRT_STEPS  = 42;
  localparam int DIV_STEPS   = 18;
  localparam int COMPS       = 3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_WAIT, ST_EDGE, ST_CROSS, ST_CROSS_WAIT,
    ST_CHECK, ST_SQ, ST_SQ_WAIT, ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV,
    ST_DIV_DONE, ST_FINISH
  } tna_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_WRITE, OP_LOAD, OP_READ, OP_EDGE, OP_CROSS, OP_SQ, OP_SQRT_INIT,
    OP_SQRT, OP_DIV_INIT, OP_DIV, OP_DIV_DONE, OP_OUT, OP_OUT_DEG
  } tna_op_t;

  typedef struct packed {
    tna_op_t    op;
    logic [3:0] idx;
  } tna_cmd_t;

  typedef struct packed {
    logic zero;
    logic out_busy;
  } tna_status_t;

endpackage

/* rtl/tna_ctrl.sv */
// Controller for the triangle normal and area block.
// Sequences vertex reads, cross product, square root and divisions.
// Depends on tna_pkg.
module tna_ctrl import tna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_func,
  output logic        in_ready,
  input  tna_status_t status,
  output tna_cmd_t    cmd
);

  tna_state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] comp, comp_next;
  logic       deg, deg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      comp  <= '0;
      deg   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      deg   <= deg_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    deg_next   = deg;
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.idx    = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_func) begin
            cmd.op = OP_WRITE;
          end else begin
            cmd.op     = OP_LOAD;
            state_next = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        cmd.op     = OP_READ;
        cmd.idx    = 4'd0;
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.op     = OP_READ;
        cmd.idx    = 4'd1;
        state_next = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.op     = OP_READ;
        cmd.idx    = 4'd2;
        state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_EDGE;
      ST_EDGE: begin
        cmd.op     = OP_EDGE;
        cnt_next   = '0;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.op  = OP_CROSS;
        cmd.idx = cnt[3:0];
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(CROSS_TERMS - 1)) begin
          state_next = ST_CROSS_WAIT;
        end
      end
      ST_CROSS_WAIT: state_next = ST_CHECK;
      ST_CHECK: begin
        deg_next = status.zero;
        cnt_next = '0;
        state_next = status.zero ? ST_FINISH : ST_SQ;
      end
      ST_SQ: begin
        cmd.op  = OP_SQ;
        cmd.idx = cnt[3:0];
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(SQ_TERMS - 1)) begin
          state_next = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: state_next = ST_SQRT_INIT;
      ST_SQRT_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op   = OP_SQRT;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          comp_next  = '0;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cmd.idx    = {2'b00, comp};
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          state_next = ST_DIV_DONE;
        end
      end
      ST_DIV_DONE: begin
        cmd.op    = OP_DIV_DONE;
        cmd.idx   = {2'b00, comp};
        comp_next = comp + 2'd1;
        state_next = (comp == 2'(COMPS - 1)) ? ST_FINISH : ST_DIV_INIT;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.op     = deg ? OP_OUT_DEG : OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/tna_datapath.sv */
// Datapath for the triangle normal and area block: vertex memory, shared
// multiplier, iterative square root and divider, output register.
// Depends on tna_pkg.
module tna_datapath import tna_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  tna_cmd_t           cmd,
  output tna_status_t        status,
  input  logic [11:0]        vertex_index,
  input  logic signed [19:0] pos_x,
  input  logic signed [19:0] pos_y,
  input  logic signed [19:0] pos_z,
  input  logic [11:0]        corner_a,
  input  logic [11:0]        corner_b,
  input  logic [11:0]        corner_c,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z,
  output logic [31:0]        area,
  output logic               degenerate
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

  logic [59:0] mem [VERTEX_DEPTH];
  logic [59:0] rdata;
  logic        rd_pend, rd_oob;
  logic [1:0]  rd_sel;
  logic [11:0] corner [3];
  logic [59:0] vert [3];

  logic [31:0] widx, ridx;
  logic [11:0] rsel_idx;

  always_comb begin
    case (cmd.idx[1:0])
      2'd0:    rsel_idx = corner[0];
      2'd1:    rsel_idx = corner[1];
      default: rsel_idx = corner[2];
    endcase
  end

  assign widx = 32'(vertex_index);
  assign ridx = 32'(rsel_idx);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && widx < 32'(VERTEX_DEPTH)) begin
      mem[widx[AW-1:0]] <= {pos_z, pos_y, pos_x};
    end
    if (cmd.op == OP_READ) begin
      rdata <= mem[ridx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (cmd.op == OP_READ);
    end
    if (cmd.op == OP_READ) begin
      rd_oob <= !(ridx < 32'(VERTEX_DEPTH));
      rd_sel <= cmd.idx[1:0];
    end
    if (cmd.op == OP_LOAD) begin
      corner[0] <= corner_a;
      corner[1] <= corner_b;
      corner[2] <= corner_c;
    end
    if (rd_pend) begin
      vert[rd_sel] <= rd_oob ? '0 : rdata;
    end
  end

  // edges, cross product, squares
  logic signed [20:0] e1 [3];
  logic signed [20:0] e2 [3];
  logic signed [42:0] n [3];
  logic [41:0]        mag [3];
  logic signed [21:0] ma, mb;
  logic signed [43:0] prod;
  logic               p_cross, p_sq;
  logic [3:0]         p_idx;
  logic [6:0]         p_sh;
  logic [6:0]         sh_sel;
  logic [83:0]        s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = n[i][42] ? 42'(-n[i]) : n[i][41:0];
    end
  end

  always_comb begin
    ma     = '0;
    mb     = '0;
    sh_sel = '0;
    case (cmd.idx)
      4'd0: begin
        ma = 22'(e1[1]); mb = 22'(e2[2]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[0][41:21]}; mb = {1'b0, mag[0][41:21]}; sh_sel = 7'd42;
        end
      end
      4'd1: begin
        ma = 22'(e1[2]); mb = 22'(e2[1]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[0][41:21]}; mb = {1'b0, mag[0][20:0]}; sh_sel = 7'd22;
        end
      end
      4'd2: begin
        ma = 22'(e1[2]); mb = 22'(e2[0]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[0][20:0]}; mb = {1'b0, mag[0][20:0]}; sh_sel = 7'd0;
        end
      end
      4'd3: begin
        ma = 22'(e1[0]); mb = 22'(e2[2]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[1][41:21]}; mb = {1'b0, mag[1][41:21]}; sh_sel = 7'd42;
        end
      end
      4'd4: begin
        ma = 22'(e1[0]); mb = 22'(e2[1]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[1][41:21]}; mb = {1'b0, mag[1][20:0]}; sh_sel = 7'd22;
        end
      end
      4'd5: begin
        ma = 22'(e1[1]); mb = 22'(e2[0]);
        if (cmd.op == OP_SQ) begin
          ma = {1'b0, mag[1][20:0]}; mb = {1'b0, mag[1][20:0]}; sh_sel = 7'd0;
        end
      end
      4'd6: begin
        ma = {1'b0, mag[2][41:21]}; mb = {1'b0, mag[2][41:21]}; sh_sel = 7'd42;
      end
      4'd7: begin
        ma = {1'b0, mag[2][41:21]}; mb = {1'b0, mag[2][20:0]}; sh_sel = 7'd22;
      end
      4'd8: begin
        ma = {1'b0, mag[2][20:0]}; mb = {1'b0, mag[2][20:0]}; sh_sel = 7'd0;
      end
      default: begin
        ma = '0; mb = '0; sh_sel = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_cross <= 1'b0;
      p_sq    <= 1'b0;
    end else begin
      p_cross <= (cmd.op == OP_CROSS);
      p_sq    <= (cmd.op == OP_SQ);
    end
    prod  <= ma * mb;
    p_idx <= cmd.idx;
    p_sh  <= sh_sel;
    if (cmd.op == OP_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= 21'($signed(vert[1][20*i +: 20])) - 21'($signed(vert[0][20*i +: 20]));
        e2[i] <= 21'($signed(vert[2][20*i +: 20])) - 21'($signed(vert[0][20*i +: 20]));
      end
      s <= '0;
    end
    if (p_cross) begin
      if (!p_idx[0]) begin
        n[p_idx[2:1]] <= prod[42:0];
      end else begin
        n[p_idx[2:1]] <= n[p_idx[2:1]] - prod[42:0];
      end
    end
    if (p_sq) begin
      s <= s + (84'(prod[41:0]) << p_sh);
    end
  end

  assign status.zero = (n[0] == '0) && (n[1] == '0) && (n[2] == '0);

  // square root, two radicand bits a step
  logic [83:0] sq_s;
  logic [45:0] rem, r4, trial;
  logic [41:0] root;

  assign r4    = {rem[43:0], sq_s[83:82]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT_INIT) begin
      sq_s <= s;
      rem  <= '0;
      root <= '0;
    end else if (cmd.op == OP_SQRT) begin
      sq_s <= {sq_s[81:0], 2'b00};
      if (r4 >= trial) begin
        rem  <= r4 - trial;
        root <= {root[40:0], 1'b1};
      end else begin
        rem  <= r4;
        root <= {root[40:0], 1'b0};
      end
    end
  end

  // restoring divider for round(mag * 2^16 / d)
  logic [59:0]        num;
  logic [43:0]        dr, r2, dvs;
  logic [17:0]        nsh, q, qc;
  logic               comp_neg;
  logic signed [17:0] nrm [3];

  assign num = (60'(mag[cmd.idx[1:0]]) << 17) + 60'(root);
  assign dvs = {1'b0, root, 1'b0};
  assign r2  = {dr[42:0], nsh[17]};

  always_comb begin
    comp_neg = n[cmd.idx[1:0]][42];
    if (comp_neg) begin
      qc = (q > 18'd131072) ? 18'd131072 : q;
      qc = 18'(-qc);
    end else begin
      qc = (q > 18'd131071) ? 18'd131071 : q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIV_INIT) begin
      dr  <= num[59:16] >> 2;
      nsh <= num[17:0];
      q   <= '0;
    end else if (cmd.op == OP_DIV) begin
      nsh <= {nsh[16:0], 1'b0};
      if (r2 >= dvs) begin
        dr <= r2 - dvs;
        q  <= {q[16:0], 1'b1};
      end else begin
        dr <= r2;
        q  <= {q[16:0], 1'b0};
      end
    end
    if (cmd.op == OP_DIV_DONE) begin
      nrm[cmd.idx[1:0]] <= qc;
    end
  end

  // output register
  logic [42:0] area_sum;
  logic [33:0] area_sh;

  assign area_sum = 43'(root) + 43'd256;
  assign area_sh  = area_sum[42:9];
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT || cmd.op == OP_OUT_DEG) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.op == OP_OUT) begin
      normal_x   <= nrm[0];
      normal_y   <= nrm[1];
      normal_z   <= nrm[2];
      area       <= (area_sh[33:32] != 2'b00) ? 32'hFFFF_FFFF : area_sh[31:0];
      degenerate <= 1'b0;
    end else if (cmd.op == OP_OUT_DEG) begin
      normal_x   <= '0;
      normal_y   <= '0;
      normal_z   <= '0;
      area       <= '0;
      degenerate <= 1'b1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT || cmd.op == OP_OUT_DEG) |-> !(out_valid && !out_ready))
    else $error("result overwritten while pending");
  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT || cmd.op == OP_OUT_DEG) |=> out_valid)
    else $error("result not presented");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_OUT_DEG) |=> (degenerate && area == '0 && normal_x == '0))
    else $error("degenerate result not zero");

endmodule

/* rtl/triangle_normal_area_top.sv */
// Top level of the triangle face normal and area block.
// Instantiates tna_ctrl and tna_datapath; depends on tna_pkg.
//
//   channel  dir  contents
//   s_*      in   vertex write (tuser=0) or face request (tuser=1)
//   m_*      out  one result word per face request
//
// Vertex words are written to the vertex memory as they are taken. A face result is loaded
// after the 42-step square root and three 18-step restoring divisions in the datapath,
// or without them for a zero cross product, and the next word can be taken in the cycle
// after that. Reset is synchronous; the vertex memory is not cleared.
// A finished result waits in the output register; the next word is taken
// meanwhile, and a new result waits only if the previous one is still held.
module triangle_normal_area_top import tna_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, pad
  input  logic [111:0] s_tdata,
  // func
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // normal_x, normal_y, normal_z, area, pad
  output logic [87:0]  m_tdata,
  // degenerate
  output logic         m_tuser
);

  tna_cmd_t           cmd;
  tna_status_t        status;
  logic signed [17:0] nx, ny, nz;
  logic [31:0]        area;

  tna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_func  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tna_datapath #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .vertex_index (s_tdata[11:0]),
    .pos_x        (s_tdata[31:12]),
    .pos_y        (s_tdata[51:32]),
    .pos_z        (s_tdata[71:52]),
    .corner_a     (s_tdata[83:72]),
    .corner_b     (s_tdata[95:84]),
    .corner_c     (s_tdata[107:96]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .normal_x     (nx),
    .normal_y     (ny),
    .normal_z     (nz),
    .area         (area),
    .degenerate   (m_tuser)
  );

  assign m_tdata = {2'b00, area, nz, ny, nx};

endmodule

/* tb/triangle_normal_area_top_tb.sv */
// Testbench for triangle_normal_area_top: vertex writes and face requests on the
// input stream, results checked against an in-bench normal/area predictor.
// Depends on tna_pkg and the RTL of triangle_normal_area_top.
module triangle_normal_area_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic [31:0]        area;
    logic               degenerate;
  } face_result_t;

  class face_scoreboard;
    logic [59:0]  vstore [4096];
    face_result_t pending [$];
    int           errors;

    function new();
      errors = 0;
    endfunction

    function longint coord(logic [59:0] w, int k);
      logic signed [19:0] c;
      c = w[k*20 +: 20];
      return longint'(c);
    endfunction

    function logic [17:0] unit_comp(longint c, longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-c) : c;
      q = ((mag << 17) + d) / (2 * d);
      if (c < 0) begin
        if (q > 131072) q = 131072;
        return 18'(-q);
      end
      if (q > 131071) q = 131071;
      return 18'(q);
    endfunction

    function void note_word(logic func, logic [11:0] vi, logic [19:0] px, logic [19:0] py,
                            logic [19:0] pz, logic [11:0] ca, logic [11:0] cb,
                            logic [11:0] cc);
      longint a [3];
      longint b [3];
      longint c [3];
      longint e1 [3];
      longint e2 [3];
      longint n [3];
      logic [127:0] s;
      logic [127:0] cand_sq;
      longint unsigned d;
      longint unsigned ar;
      face_result_t r;
      if (!func) begin
        vstore[vi] = {pz, py, px};
        return;
      end
      for (int k = 0; k < 3; k++) begin
        a[k] = coord(vstore[ca], k);
        b[k] = coord(vstore[cb], k);
        c[k] = coord(vstore[cc], k);
        e1[k] = b[k] - a[k];
        e2[k] = c[k] - a[k];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      r = '0;
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
        r.degenerate = 1'b1;
      end else begin
        s = 0;
        for (int k = 0; k < 3; k++)
          s += 128'(n[k] < 0 ? -n[k] : n[k]) * 128'(n[k] < 0 ? -n[k] : n[k]);
        d = 0;
        for (int bt = 43; bt >= 0; bt--) begin
          cand_sq = 128'(d | (64'd1 << bt)) * 128'(d | (64'd1 << bt));
          if (cand_sq <= s) d = d | (64'd1 << bt);
        end
        r.nx = unit_comp(n[0], d);
        r.ny = unit_comp(n[1], d);
        r.nz = unit_comp(n[2], d);
        ar = (d + 256) >> 9;
        r.area = (ar > 64'hFFFFFFFF) ? 32'hFFFFFFFF : ar[31:0];
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_word(logic [87:0] data, logic deg);
      face_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[17:0] !== e.nx) begin
        $error("normal_x expected %h got %h", e.nx, data[17:0]); errors++;
      end
      if (data[35:18] !== e.ny) begin
        $error("normal_y expected %h got %h", e.ny, data[35:18]); errors++;
      end
      if (data[53:36] !== e.nz) begin
        $error("normal_z expected %h got %h", e.nz, data[53:36]); errors++;
      end
      if (data[85:54] !== e.area) begin
        $error("area expected %h got %h", e.area, data[85:54]); errors++;
      end
      if (deg !== e.degenerate) begin
        $error("degenerate expected %b got %b", e.degenerate, deg); errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [111:0] s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [87:0]  m_tdata;
  logic         m_tuser;

  face_scoreboard sb;
  bit             written [4096];
  int             written_list [$];
  bit             quiet;
  bit             hold_rx;
  longint         cycles;

  triangle_normal_area_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("triangle_normal_area_top_tb: errors");
        $finish;
      end
    end
  end

  // one word per call; random gaps before it unless quiet
  task automatic send_word(logic func, logic [11:0] vi, logic [19:0] px, logic [19:0] py,
                           logic [19:0] pz, logic [11:0] ca, logic [11:0] cb,
                           logic [11:0] cc);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, cc, cb, ca, pz, py, px, vi};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(func, vi, px, py, pz, ca, cb, cc);
    if (!func) begin
      if (!written[vi]) written_list.insert(written_list.size(), int'(vi));
      written[vi] = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic send_vertex(logic [11:0] vi, logic [19:0] px, logic [19:0] py,
                             logic [19:0] pz);
    send_word(1'b0, vi, px, py, pz, 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic send_face(logic [11:0] ca, logic [11:0] cb, logic [11:0] cc);
    send_word(1'b1, 12'($urandom), 20'($urandom), 20'($urandom), 20'($urandom), ca, cb, cc);
  endtask

  function automatic logic [19:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2: return 20'($urandom_range(0, 7)) - 20'd3;
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_written();
    return 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // receiver: random stalls, one long hold-off while hold_rx is set
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (1500) @(negedge clk);
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
  end

  initial begin
    logic [11:0] v;
    sb = new();
    quiet = 1'b0;
    hold_rx = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, degenerate, top/bottom slots
    send_vertex(12'd0, 20'h80000, 20'h80000, 20'h80000);
    send_vertex(12'd4095, 20'h7FFFF, 20'h80000, 20'h7FFFF);
    send_vertex(12'd1, 20'h80000, 20'h7FFFF, 20'h7FFFF);
    send_vertex(12'd2, 20'h7FFFF, 20'h7FFFF, 20'h80000);
    send_vertex(12'd3, 20'h00000, 20'h00000, 20'h00000);
    send_vertex(12'd4, 20'h40000, 20'h00000, 20'h00000);
    send_vertex(12'd5, 20'h00000, 20'h40000, 20'h00000);
    send_vertex(12'd6, 20'h00001, 20'h00001, 20'h00001);
    send_vertex(12'd7, 20'hFFFFF, 20'h00000, 20'h00001);
    send_face(12'd0, 12'd4095, 12'd1);
    send_face(12'd4095, 12'd1, 12'd2);
    send_face(12'd3, 12'd4, 12'd5);
    send_face(12'd3, 12'd5, 12'd4);
    send_face(12'd3, 12'd3, 12'd4);
    send_face(12'd3, 12'd6, 12'd6);
    send_face(12'd3, 12'd6, 12'd7);
    send_face(12'd0, 12'd3, 12'd6);
    send_face(12'd6, 12'd7, 12'd0);

    // long receiver hold-off while faces keep coming
    hold_rx = 1'b1;
    for (int i = 0; i < 12; i++) send_face(pick_written(), pick_written(), pick_written());

    for (int i = 0; i < 380; i++) begin
      if (i == 320) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0 || written_list.size() < 6) begin
        v = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
        send_vertex(v, rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_face(pick_written(), pick_written(), pick_written());
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("triangle_normal_area_top_tb: clean");
    end else begin
      $display("triangle_normal_area_top_tb: errors");
    end
    $finish;
  end
endmodule
